// ----- src/hmpp_pkg.sv -----
// Shared types, constants and tag tables for the HLS media playlist parser.
// Used by hmpp_front, hmpp_back and the top level; no dependencies.
package hmpp_pkg;

    // Limits of the playlist.
    localparam int MAX_SEGMENTS = 32;
    localparam int URI_CAPACITY = 256;
    localparam int SEG_W = ($clog2(MAX_SEGMENTS + 1) > 6) ? $clog2(MAX_SEGMENTS + 1) : 6;
    localparam int UL_W  = $clog2(URI_CAPACITY + 1);

    // Depth of the two small queues.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Line classes.
    localparam logic [2:0] LC_TAG  = 3'd0;
    localparam logic [2:0] LC_SEQ  = 3'd1;
    localparam logic [2:0] LC_TGT  = 3'd2;
    localparam logic [2:0] LC_INF  = 3'd3;
    localparam logic [2:0] LC_URI  = 3'd4;
    localparam logic [2:0] LC_SKIP = 3'd5;

    // Main action carried by an operation bundle.
    localparam logic [1:0] MAIN_NONE = 2'd0;
    localparam logic [1:0] MAIN_CHAR = 2'd1;
    localparam logic [1:0] MAIN_EOL  = 2'd2;

    // Record kinds.
    localparam logic [1:0] KIND_URI = 2'd0;
    localparam logic [1:0] KIND_SEG = 2'd1;
    localparam logic [1:0] KIND_FIN = 2'd2;

    // Tags: media sequence, target duration, EXTINF, ENDLIST, header.
    localparam int NUM_TAGS = 5;
    localparam int TAG_BITS = 176;
    localparam logic [TAG_BITS-1:0] TAG_STR [NUM_TAGS] = '{
        TAG_BITS'("#EXT-X-MEDIA-SEQUENCE:"),
        TAG_BITS'("#EXT-X-TARGETDURATION:"),
        TAG_BITS'("#EXTINF:"),
        TAG_BITS'("#EXT-X-ENDLIST"),
        TAG_BITS'("#EXTM3U")
    };
    localparam logic [4:0] TAG_LEN [NUM_TAGS] = '{5'd22, 5'd22, 5'd8, 5'd14, 5'd7};
    localparam int TAG_ENDLIST = 3;
    localparam int TAG_HEADER  = 4;

    localparam logic [31:0] INF_WHOLE_MAX = 32'd4294967;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  uri_char;
        logic [4:0]  segment_index;
        logic [31:0] seg_millis;
        logic [31:0] sequence_number;
        logic        parse_ok;
        logic [31:0] base_sequence;
        logic [31:0] target_duration_s;
        logic        end_list_seen;
        logic [5:0]  segment_total;
        logic        last_of_run;
    } t_res;

    // One accepted byte, split into the steps that the back end carries out.
    typedef struct packed {
        logic       cr_char;
        logic [1:0] main;
        logic [7:0] text;
        logic       tail_eol;
        logic       fin;
    } t_op;

    // Character of a tag at a position; only meaningful below the tag length.
    function automatic logic [7:0] tag_char(input logic [TAG_BITS-1:0] s,
                                            input logic [4:0] len,
                                            input logic [4:0] pos);
        logic [TAG_BITS-1:0] sh;
        sh = s >> {len - 5'd1 - pos, 3'b000};
        return sh[7:0];
    endfunction

endpackage

// ----- src/hls_media_playlist_parser.sv -----
// HLS media playlist parser: one text byte per beat in, records out through a queue.
// The back end runs a byte's steps in order (held CR, the byte itself, a closing line end,
// the final record), one step per cycle unless a new record finds the hold register and the
// result queue both full; a plain byte has one step, a byte four at most. A byte's records
// pass from the operation queue through the hold register into the result queue.
// Reset (synchronous, active low) empties both queues and clears all parser state.
module hls_media_playlist_parser import hmpp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_res o_res
);

    logic op_valid, op_pop;
    t_op  op;

    // Front end: byte classification and operation queue.
    hmpp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_op_pop   (op_pop)
    );

    // Back end: parser steps and result queue.
    hmpp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_op_pop   (op_pop),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res)
    );

endmodule

// ----- src/hmpp_front.sv -----
// Front end: handles the held carriage return and turns each byte into an operation bundle.
// Holds the small operation queue towards the back end. Depends on hmpp_pkg.
module hmpp_front import hmpp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic o_op_valid,
    output t_op  o_op,
    input  logic i_op_pop
);

    logic            r_cr_held;
    t_op             r_q [Q_DEPTH];
    logic [Q_AW:0]   r_wp, r_rp;
    logic [Q_AW:0]   fill;
    logic            take, is_lf, is_cr;
    t_op             op;

    assign fill       = r_wp - r_rp;
    assign full       = (fill == (Q_AW + 1)'(Q_DEPTH));
    assign take       = push && !full;
    assign o_op_valid = (fill != '0);
    assign o_op       = r_q[r_rp[Q_AW-1:0]];

    assign is_lf = (i_item.text_byte == 8'h0A);
    assign is_cr = (i_item.text_byte == 8'h0D);

    // Classify the beat: a held CR is either a line end or an ordinary character.
    always_comb begin
        op.text     = i_item.text_byte;
        op.fin      = i_item.last_byte;
        op.tail_eol = i_item.last_byte && !is_lf;
        if (r_cr_held && is_lf) begin
            op.cr_char = 1'b0;
            op.main    = MAIN_EOL;
        end else begin
            op.cr_char = r_cr_held;
            if (is_lf) begin
                op.main = MAIN_EOL;
            end else if (is_cr) begin
                op.main = MAIN_NONE;
            end else begin
                op.main = MAIN_CHAR;
            end
        end
    end

    // Queue write side.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wp[Q_AW-1:0]] <= op;
        end
    end

    // Pointers and the held CR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_cr_held <= 1'b0;
        end else begin
            if (take) begin
                r_wp      <= r_wp + 1'b1;
                r_cr_held <= is_cr && !i_item.last_byte;
            end
            if (i_op_pop && o_op_valid) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

// ----- src/hmpp_back.sv -----
// Back end: runs the parser one step per cycle unless a record waits for room, and queues the records.
// A hold register delays each record until its last-of-run mark is known. Depends on hmpp_pkg.
module hmpp_back import hmpp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_op_valid,
    input  t_op  i_op,
    output logic o_op_pop,
    output logic empty,
    input  logic pop,
    output t_res o_res
);

    localparam logic [1:0] ACT_CHAR = 2'd0;
    localparam logic [1:0] ACT_EOL  = 2'd1;
    localparam logic [1:0] ACT_FIN  = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    // Parser state.
    logic             r_hdr, n_hdr, r_err, n_err, r_dp, n_dp, r_endl, n_endl;
    logic [2:0]       r_lc, n_lc, r_nf, n_nf;
    logic [4:0]       r_mp, n_mp, r_tc, n_tc;
    logic [31:0]      r_va, n_va, r_pd, n_pd, r_seq, n_seq, r_tgt, n_tgt;
    logic [9:0]       r_fv, n_fv;
    logic [1:0]       r_fc, n_fc;
    logic [SEG_W-1:0] r_seg, n_seg;
    logic [UL_W-1:0]  r_ul, n_ul;

    // Step sequencing inside one bundle.
    logic [3:0] r_done, pend, cur, rest;
    logic [1:0] act;
    logic [7:0] c;
    logic       final_step, go;

    // Hold register and output queue.
    t_res            r_hold;
    logic            r_h, r_hd, ofull, opush;
    t_res            r_oq [Q_DEPTH];
    logic [Q_AW:0]   r_owp, r_orp, ofill;

    // Combinational step results.
    logic        rec_v;
    t_res        rec;
    logic        dig;
    logic [3:0]  d;
    logic [35:0] mul10;
    logic [4:0]  cand, nc;
    logic        fin_ok;
    logic [9:0]  fscaled;
    logic [32:0] total;
    logic [UL_W-1:0] ul_inc;

    // Pick the first step still pending in the bundle.
    always_comb begin
        pend = {i_op.fin, i_op.tail_eol, i_op.main != MAIN_NONE, i_op.cr_char} & ~r_done;
        c    = i_op.text;
        if (pend[0]) begin
            cur = 4'b0001;
            act = ACT_CHAR;
            c   = 8'h0D;
        end else if (pend[1]) begin
            cur = 4'b0010;
            act = (i_op.main == MAIN_EOL) ? ACT_EOL : ACT_CHAR;
        end else if (pend[2]) begin
            cur = 4'b0100;
            act = ACT_EOL;
        end else if (pend[3]) begin
            cur = 4'b1000;
            act = ACT_FIN;
        end else begin
            cur = 4'b0000;
            act = ACT_NOP;
        end
        rest       = pend & ~cur;
        final_step = (rest == 4'b0000);
    end

    // Digit arithmetic, tag matching and the EXTINF millisecond value.
    always_comb begin
        dig   = (c >= "0") && (c <= "9");
        d     = dig ? 4'(c - "0") : 4'd0;
        mul10 = {4'b0, r_va} * 36'd10 + 36'(d);
        unique case (r_fc)
            2'd0:    fscaled = 10'd0;
            2'd1:    fscaled = 10'(r_fv * 10'd100);
            2'd2:    fscaled = 10'(r_fv * 10'd10);
            default: fscaled = r_fv;
        endcase
        total  = 33'(r_va[22:0]) * 33'd1000 + 33'(fscaled);
        fin_ok = r_nf[1] && !total[32];
        ul_inc = r_ul + 1'b1;
        for (int k = 0; k < NUM_TAGS; k++) begin
            cand[k] = r_tc[k] && (r_hdr ? (k != TAG_HEADER) : (k == TAG_HEADER));
            nc[k]   = cand[k] && (r_mp < TAG_LEN[k]) &&
                      (tag_char(TAG_STR[k], TAG_LEN[k], r_mp) == c);
        end
    end

    // Parser step.
    always_comb begin
        n_hdr = r_hdr; n_err = r_err; n_dp = r_dp; n_endl = r_endl;
        n_lc = r_lc; n_nf = r_nf; n_mp = r_mp; n_tc = r_tc;
        n_va = r_va; n_pd = r_pd; n_seq = r_seq; n_tgt = r_tgt;
        n_fv = r_fv; n_fc = r_fc; n_seg = r_seg; n_ul = r_ul;
        rec_v = 1'b0;
        rec   = '0;
        unique case (act)
            ACT_CHAR: begin
                if (!r_err) begin
                    unique case (r_lc)
                        LC_TAG: begin
                            if (r_hdr && r_mp == 5'd0 && c != "#") begin
                                if (!r_dp || r_seg >= SEG_W'(MAX_SEGMENTS)) begin
                                    n_err = 1'b1;
                                end else begin
                                    // First URI byte: length starts at one.
                                    n_lc  = LC_URI;
                                    n_ul  = UL_W'(1);
                                    rec_v = 1'b1;
                                    rec.record_kind   = KIND_URI;
                                    rec.uri_char      = c;
                                    rec.segment_index = r_seg[4:0];
                                end
                            end else begin
                                n_tc = nc;
                                n_mp = r_mp + 5'd1;
                                if (nc == 5'd0) begin
                                    if (!r_hdr) begin
                                        n_err = 1'b1;
                                    end else begin
                                        n_lc = LC_SKIP;
                                    end
                                end else begin
                                    for (int k = 0; k < 3; k++) begin
                                        if (nc[k] && (r_mp + 5'd1) == TAG_LEN[k]) begin
                                            n_lc = 3'(k + 1);
                                            n_va = '0; n_fv = '0; n_fc = '0; n_nf = '0;
                                        end
                                    end
                                end
                            end
                        end
                        LC_SEQ, LC_TGT: begin
                            if (!dig || mul10 > 36'hFFFFFFFF) begin
                                n_err = 1'b1;
                            end else begin
                                n_va = mul10[31:0];
                                n_nf = r_nf | 3'b010;
                            end
                        end
                        LC_INF: begin
                            if (c == ",") begin
                                if (fin_ok) begin
                                    n_pd = total[31:0];
                                    n_dp = 1'b1;
                                end else begin
                                    n_err = 1'b1;
                                end
                                n_lc = LC_SKIP;
                            end else if (c == ".") begin
                                if (r_nf[0]) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_nf = r_nf | 3'b001;
                                end
                            end else if (!dig) begin
                                n_err = 1'b1;
                            end else if (!r_nf[0]) begin
                                n_nf = r_nf | 3'b010;
                                if (mul10 > 36'(INF_WHOLE_MAX)) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_va = mul10[31:0];
                                end
                            end else begin
                                n_nf = r_nf | 3'b010;
                                if (r_fc < 2'd3) begin
                                    n_fv = 10'(r_fv * 10'd10) + 10'(d);
                                    n_fc = r_fc + 2'd1;
                                end
                            end
                        end
                        LC_URI: begin
                            if (ul_inc >= UL_W'(URI_CAPACITY)) begin
                                n_err = 1'b1;
                            end else begin
                                n_ul  = ul_inc;
                                rec_v = 1'b1;
                                rec.record_kind   = KIND_URI;
                                rec.uri_char      = c;
                                rec.segment_index = r_seg[4:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ACT_EOL: begin
                if (!r_err) begin
                    if (!r_hdr) begin
                        if (r_lc == LC_TAG && r_tc[TAG_HEADER] && r_mp == TAG_LEN[TAG_HEADER]) begin
                            n_hdr = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (r_lc == LC_SEQ || r_lc == LC_TGT) begin
                        if (!r_nf[1]) begin
                            n_err = 1'b1;
                        end else if (r_lc == LC_SEQ) begin
                            n_seq = r_va;
                        end else begin
                            n_tgt = r_va;
                        end
                    end else if (r_lc == LC_INF) begin
                        if (fin_ok) begin
                            n_pd = total[31:0];
                            n_dp = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (r_lc == LC_URI) begin
                        rec_v = 1'b1;
                        rec.record_kind     = KIND_SEG;
                        rec.segment_index   = r_seg[4:0];
                        rec.seg_millis      = r_pd;
                        rec.sequence_number = r_seq + 32'(r_seg);
                        n_seg = r_seg + 1'b1;
                        n_dp  = 1'b0;
                    end else if (r_lc == LC_TAG) begin
                        if (r_tc[TAG_ENDLIST] && r_mp == TAG_LEN[TAG_ENDLIST]) begin
                            n_endl = 1'b1;
                        end
                    end
                end
                // Every line end restarts the line scan.
                n_lc = LC_TAG; n_mp = '0; n_tc = '1; n_ul = '0;
                n_va = '0; n_fv = '0; n_fc = '0; n_nf = '0;
            end
            ACT_FIN: begin
                rec_v = 1'b1;
                rec.record_kind       = KIND_FIN;
                rec.parse_ok          = !r_err && r_hdr && (r_seg != '0) && !r_dp &&
                                        (r_tgt != '0);
                rec.base_sequence     = r_seq;
                rec.target_duration_s = r_tgt;
                rec.end_list_seen     = r_endl;
                rec.segment_total     = r_seg[5:0];
                // Start a fresh playlist.
                n_hdr = 1'b0; n_err = 1'b0; n_dp = 1'b0; n_endl = 1'b0;
                n_lc = LC_TAG; n_mp = '0; n_tc = '1; n_ul = '0;
                n_va = '0; n_fv = '0; n_fc = '0; n_nf = '0;
                n_pd = '0; n_seq = '0; n_tgt = '0; n_seg = '0;
            end
            default: begin
            end
        endcase
    end

    // A step runs when its record, if any, has room: the hold register is free or the result queue is not full.
    assign ofill    = r_owp - r_orp;
    assign ofull    = (ofill == (Q_AW + 1)'(Q_DEPTH));
    assign empty    = (ofill == '0);
    assign o_res    = r_oq[r_orp[Q_AW-1:0]];
    assign go       = i_op_valid && (!r_h || !rec_v || !ofull);
    assign o_op_pop = go && final_step;
    assign opush    = r_h && (r_hd || (go && rec_v)) && !ofull;

    // Parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= 1'b0; r_err <= 1'b0; r_dp <= 1'b0; r_endl <= 1'b0;
            r_lc <= LC_TAG; r_nf <= '0; r_mp <= '0; r_tc <= '1;
            r_va <= '0; r_pd <= '0; r_seq <= '0; r_tgt <= '0;
            r_fv <= '0; r_fc <= '0; r_seg <= '0; r_ul <= '0;
            r_done <= '0;
        end else if (go) begin
            r_hdr <= n_hdr; r_err <= n_err; r_dp <= n_dp; r_endl <= n_endl;
            r_lc <= n_lc; r_nf <= n_nf; r_mp <= n_mp; r_tc <= n_tc;
            r_va <= n_va; r_pd <= n_pd; r_seq <= n_seq; r_tgt <= n_tgt;
            r_fv <= n_fv; r_fc <= n_fc; r_seg <= n_seg; r_ul <= n_ul;
            r_done <= final_step ? 4'b0000 : (r_done | cur);
        end
    end

    // Hold register: the mark is set once the bundle has no steps left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h  <= 1'b0;
            r_hd <= 1'b0;
        end else if (go && rec_v) begin
            r_h  <= 1'b1;
            r_hd <= final_step;
        end else if (opush) begin
            r_h  <= 1'b0;
            r_hd <= 1'b0;
        end else if (go && final_step && r_h) begin
            r_hd <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && rec_v) begin
            r_hold <= rec;
        end
    end

    // Output queue.
    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_oq[r_owp[Q_AW-1:0]] <= '{
                record_kind:       r_hold.record_kind,
                uri_char:          r_hold.uri_char,
                segment_index:     r_hold.segment_index,
                seg_millis:        r_hold.seg_millis,
                sequence_number:   r_hold.sequence_number,
                parse_ok:          r_hold.parse_ok,
                base_sequence:     r_hold.base_sequence,
                target_duration_s: r_hold.target_duration_s,
                end_list_seen:     r_hold.end_list_seen,
                segment_total:     r_hold.segment_total,
                last_of_run:       r_hd
            };
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp <= '0;
            r_orp <= '0;
        end else begin
            if (opush) begin
                r_owp <= r_owp + 1'b1;
            end
            if (pop && !empty) begin
                r_orp <= r_orp + 1'b1;
            end
        end
    end

endmodule
